[rtl/core/mbrdi_pkg.sv]
// shared types and constants for the modbus read-input-registers client
`default_nettype none
package mbrdi_pkg;

    typedef enum logic [1:0] {
        ACT_START    = 2'd0,
        ACT_BYTE     = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_LINK_ERR = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_COUNT = 3'd1;
    localparam logic [2:0] ST_TIMEOUT   = 3'd2;
    localparam logic [2:0] ST_LINK_ERR  = 3'd3;
    localparam logic [2:0] ST_ID_MISM   = 3'd4;
    localparam logic [2:0] ST_EXCEPTION = 3'd5;
    localparam logic [2:0] ST_BAD_FUNC  = 3'd6;

    localparam logic       CFG_UNIT_ID = 1'b0;
    localparam logic       CFG_TIMEOUT = 1'b1;

    localparam logic [7:0]  UNIT_ID_RST  = 8'd1;
    localparam logic [15:0] TIMEOUT_RST  = 16'd1000;

    localparam logic [7:0] FUNC_RD_INPUT = 8'h04;
    localparam int         EXC_BIT       = 7;
    localparam logic [7:0] PDU_LEN       = 8'h06;
    localparam logic [7:0] PROTO_ID_BYTE = 8'h00;
    localparam logic [7:0] HDR_LAST_POS  = 8'd8;
    localparam logic [3:0] REQ_LAST_SEQ  = 4'd11;

    localparam int Q_DEPTH = 4;

    // one unit of work handed from the parser to the output sequencer
    typedef struct packed {
        t_kind       kind;
        logic [15:0] txn;
        logic [7:0]  unit;
        logic [15:0] addr;
        logic [6:0]  idx;    // register count for a request, word index otherwise
        logic [15:0] value;
        logic [2:0]  status;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage
`default_nettype wire

[rtl/core/mbrdi_front.sv]
// input parser: transaction state, header checks, timeouts and command generation
`default_nettype none
module mbrdi_front #(
    parameter int MAX_REGS = 125
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [15:0]   i_cfg_data,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [1:0]    i_action,
    input  wire logic [15:0]   i_start_addr,
    input  wire logic [15:0]   i_reg_count,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_q_full,
    output logic               o_push,
    output mbrdi_pkg::t_cmd    o_cmd
);
    import mbrdi_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_HEADER = 3'b010,
        PH_DATA   = 3'b100
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_txn, n_txn;
    logic [6:0]  r_exp, n_exp;
    logic [7:0]  r_pos, n_pos;
    logic [15:0] r_elapsed, n_elapsed;
    logic [7:0]  r_hold, n_hold;
    logic [7:0]  r_unit_id;
    logic [15:0] r_timeout;
    logic [7:0]  r_hdr [8];

    logic        w_acc;
    t_action     w_act;
    logic        w_fail;
    logic [2:0]  w_fail_st;
    logic [15:0] w_el_inc;
    logic [7:0]  w_word_next;

    assign o_in_ready = !i_q_full;
    assign w_acc      = i_in_valid && !i_q_full;
    assign w_act      = t_action'(i_action);
    assign w_el_inc   = r_elapsed + 16'd1;
    assign w_word_next = {1'b0, r_pos[7:1]} + 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_txn     = r_txn;
        n_exp     = r_exp;
        n_pos     = r_pos;
        n_elapsed = r_elapsed;
        n_hold    = r_hold;
        w_fail    = 1'b0;
        w_fail_st = ST_OK;
        o_push    = 1'b0;
        o_cmd     = '0;
        if (w_acc) begin
            case (w_act)
                ACT_START: begin
                    if (r_phase == PH_IDLE) begin
                        if (i_reg_count == 16'd0 || i_reg_count > 16'(MAX_REGS)) begin
                            w_fail    = 1'b1;
                            w_fail_st = ST_BAD_COUNT;
                        end else begin
                            n_txn      = r_txn + 16'd1;
                            o_push     = 1'b1;
                            o_cmd.kind = KIND_TX;
                            o_cmd.txn  = n_txn;
                            o_cmd.unit = r_unit_id;
                            o_cmd.addr = i_start_addr;
                            o_cmd.idx  = i_reg_count[6:0];
                            n_exp      = i_reg_count[6:0];
                            n_phase    = PH_HEADER;
                            n_pos      = '0;
                            n_elapsed  = '0;
                        end
                    end
                end
                ACT_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        n_elapsed = w_el_inc;
                        // a wrapped counter also counts as expired
                        if (w_el_inc >= r_timeout || w_el_inc == 16'd0) begin
                            w_fail    = 1'b1;
                            w_fail_st = ST_TIMEOUT;
                        end
                    end
                end
                ACT_LINK_ERR: begin
                    if (r_phase != PH_IDLE) begin
                        w_fail    = 1'b1;
                        w_fail_st = ST_LINK_ERR;
                    end
                end
                ACT_BYTE: begin
                    if (r_phase == PH_HEADER) begin
                        n_pos = r_pos + 8'd1;
                        if (r_pos == HDR_LAST_POS) begin
                            // header byte 8 (byte count) is checked straight off the input
                            if ({r_hdr[0], r_hdr[1]} != r_txn || r_hdr[6] != r_unit_id) begin
                                w_fail    = 1'b1;
                                w_fail_st = ST_ID_MISM;
                            end else if (r_hdr[7][EXC_BIT]) begin
                                w_fail    = 1'b1;
                                w_fail_st = ST_EXCEPTION;
                            end else if (r_hdr[7] != FUNC_RD_INPUT
                                         || i_rx_byte != {r_exp, 1'b0}) begin
                                w_fail    = 1'b1;
                                w_fail_st = ST_BAD_FUNC;
                            end else begin
                                n_phase   = PH_DATA;
                                n_pos     = '0;
                                n_elapsed = '0;
                            end
                        end
                    end else if (r_phase == PH_DATA) begin
                        n_pos = r_pos + 8'd1;
                        if (!r_pos[0]) begin
                            n_hold = i_rx_byte;
                        end else begin
                            o_push      = 1'b1;
                            o_cmd.kind  = KIND_WORD;
                            o_cmd.idx   = r_pos[7:1];
                            o_cmd.value = {r_hold, i_rx_byte};
                            o_cmd.last  = (w_word_next >= {1'b0, r_exp});
                            if (w_word_next >= {1'b0, r_exp}) begin
                                n_phase   = PH_IDLE;
                                n_pos     = '0;
                                n_elapsed = '0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (w_fail) begin
            n_phase      = PH_IDLE;
            n_pos        = '0;
            n_elapsed    = '0;
            o_push       = 1'b1;
            o_cmd        = '0;
            o_cmd.kind   = KIND_STATUS;
            o_cmd.status = w_fail_st;
            o_cmd.last   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_txn     <= '0;
            r_exp     <= '0;
            r_pos     <= '0;
            r_elapsed <= '0;
            r_hold    <= '0;
            r_unit_id <= UNIT_ID_RST;
            r_timeout <= TIMEOUT_RST;
        end else begin
            r_phase   <= n_phase;
            r_txn     <= n_txn;
            r_exp     <= n_exp;
            r_pos     <= n_pos;
            r_elapsed <= n_elapsed;
            r_hold    <= n_hold;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_UNIT_ID: r_unit_id <= i_cfg_data[7:0];
                    CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // header bytes 0..7 kept; byte 8 is used as it arrives
    always_ff @(posedge i_clk) begin
        if (w_acc && w_act == ACT_BYTE && r_phase == PH_HEADER && r_pos < HDR_LAST_POS) begin
            r_hdr[r_pos[2:0]] <= i_rx_byte;
        end
    end

endmodule
`default_nettype wire

[rtl/core/mbrdi_queue.sv]
// small command queue between the parser and the output sequencer
`default_nettype none
module mbrdi_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mbrdi_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output mbrdi_pkg::t_q_head  o_head,
    output logic                o_full
);
    import mbrdi_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    t_cmd          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_full     = (r_cnt == (PW+1)'(Q_DEPTH));
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

[rtl/core/mbrdi_back.sv]
// output sequencer: expands commands into result items behind an output register
`default_nettype none
module mbrdi_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mbrdi_pkg::t_q_head i_head,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [1:0]             o_out_kind,
    output logic [7:0]             o_tx_byte,
    output logic [6:0]             o_reg_index,
    output logic [15:0]            o_reg_value,
    output logic [2:0]             o_status,
    output logic                   o_close_link,
    output logic                   o_last
);
    import mbrdi_pkg::*;

    logic        r_valid;
    logic [3:0]  r_seq, n_seq;
    t_kind       r_kind;
    logic [7:0]  r_tx;
    logic [6:0]  r_idx;
    logic [15:0] r_val;
    logic [2:0]  r_st;
    logic        r_cl;
    logic        r_last;
    logic        w_adv;
    logic        w_load;
    logic [7:0]  w_req_byte;
    t_cmd        w_c;

    assign w_c    = i_head.cmd;
    assign w_adv  = !r_valid || i_out_ready;
    assign w_load = w_adv && i_head.valid;

    // request frame: mbap header then pdu
    always_comb begin
        case (r_seq)
            4'd0:    w_req_byte = w_c.txn[15:8];
            4'd1:    w_req_byte = w_c.txn[7:0];
            4'd5:    w_req_byte = PDU_LEN;
            4'd6:    w_req_byte = w_c.unit;
            4'd7:    w_req_byte = FUNC_RD_INPUT;
            4'd8:    w_req_byte = w_c.addr[15:8];
            4'd9:    w_req_byte = w_c.addr[7:0];
            4'd10:   w_req_byte = 8'h00;
            4'd11:   w_req_byte = {1'b0, w_c.idx};
            default: w_req_byte = PROTO_ID_BYTE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        n_seq = r_seq;
        if (w_load) begin
            if (w_c.kind == KIND_TX && r_seq != REQ_LAST_SEQ) begin
                n_seq = r_seq + 4'd1;
            end else begin
                n_seq = '0;
                o_pop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_seq   <= '0;
        end else begin
            r_seq <= n_seq;
            if (w_adv) begin
                r_valid <= i_head.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= w_c.kind;
            case (w_c.kind)
                KIND_TX: begin
                    r_tx   <= w_req_byte;
                    r_idx  <= '0;
                    r_val  <= '0;
                    r_st   <= ST_OK;
                    r_cl   <= 1'b0;
                    r_last <= (r_seq == REQ_LAST_SEQ);
                end
                KIND_WORD: begin
                    r_tx   <= '0;
                    r_idx  <= w_c.idx;
                    r_val  <= w_c.value;
                    r_st   <= ST_OK;
                    r_cl   <= 1'b0;
                    r_last <= w_c.last;
                end
                default: begin
                    r_tx   <= '0;
                    r_idx  <= '0;
                    r_val  <= '0;
                    r_st   <= w_c.status;
                    r_cl   <= 1'b1;
                    r_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid  = r_valid;
    assign o_out_kind   = r_kind;
    assign o_tx_byte    = r_tx;
    assign o_reg_index  = r_idx;
    assign o_reg_value  = r_val;
    assign o_status     = r_st;
    assign o_close_link = r_cl;
    assign o_last       = r_last;

endmodule
`default_nettype wire

[rtl/core/modbus_tcp_read_input_client.sv]
// top level of the modbus tcp read-input-registers client
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready   i_action i_start_addr i_reg_count i_rx_byte
//  out       output     o_out_valid / i_out_ready o_out_kind o_tx_byte o_reg_index
//                                                 o_reg_value o_status o_close_link o_last
//  cfg       input      i_cfg_we (no wait)        i_cfg_index i_cfg_data
//
// every input item is parsed in the cycle it is accepted; one per cycle while the
// four-entry command queue has room
// results leave at one per cycle from the output register while i_out_ready is high;
// a start expands into 12 request bytes, so the burst of request bytes is what backs up the queue
// an accepted item is registered into the queue and then into the output register
// synchronous active-low reset empties the queue and output register and returns to idle
`default_nettype none
module modbus_tcp_read_input_client #(
    parameter int MAX_REGS = 125
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_start_addr,
    input  wire logic [15:0] i_reg_count,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_out_kind,
    output logic [7:0]       o_tx_byte,
    output logic [6:0]       o_reg_index,
    output logic [15:0]      o_reg_value,
    output logic [2:0]       o_status,
    output logic             o_close_link,
    output logic             o_last
);
    import mbrdi_pkg::*;

    logic    w_push;
    t_cmd    w_cmd;
    logic    w_full;
    logic    w_pop;
    t_q_head w_head;

    mbrdi_front #(
        .MAX_REGS(MAX_REGS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_start_addr(i_start_addr),
        .i_reg_count (i_reg_count),
        .i_rx_byte   (i_rx_byte),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    mbrdi_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_cmd),
        .i_pop  (w_pop),
        .o_head (w_head),
        .o_full (w_full)
    );

    mbrdi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_kind  (o_out_kind),
        .o_tx_byte   (o_tx_byte),
        .o_reg_index (o_reg_index),
        .o_reg_value (o_reg_value),
        .o_status    (o_status),
        .o_close_link(o_close_link),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

[rtl/core/mbrdi_checker.sv]
// port-level checks for the modbus client, bound to the top level
`default_nettype none
module mbrdi_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  o_out_kind,
    input wire logic [7:0]  o_tx_byte,
    input wire logic [2:0]  o_status,
    input wire logic        o_close_link,
    input wire logic        o_last
);
    import mbrdi_pkg::*;

    // a stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_tx_byte)
            && $stable(o_out_kind) && $stable(o_status) && $stable(o_last))
        else $error("output item changed while stalled");

    // close goes with every failure status and only with it
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_close_link == (o_out_kind == KIND_STATUS)))
        else $error("close_link does not match item kind");

    // status-only items always end their burst
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_STATUS |-> o_last && o_status != ST_OK)
        else $error("status item without last or with ok status");

    // a request frame is sent without gaps or other items in between
    a_req_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_kind == KIND_TX && !o_last
            |=> o_out_valid && o_out_kind == KIND_TX)
        else $error("request frame interrupted");

endmodule

bind modbus_tcp_read_input_client mbrdi_checker u_mbrdi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_kind  (o_out_kind),
    .o_tx_byte   (o_tx_byte),
    .o_status    (o_status),
    .o_close_link(o_close_link),
    .o_last      (o_last)
);
`default_nettype wire
